/* rtl/core/bit_vector_engine_top_assert.svh */
// Assertion macros for the bit vector engine checker.
// Expects clk and rst_n in the scope of each use.
`ifndef BIT_VECTOR_ENGINE_TOP_ASSERT_SVH
`define BIT_VECTOR_ENGINE_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset
`define BVE_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset
`define BVE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/bve_pkg.sv */
// Package for the bit vector engine: field widths, command codes, state types
// and the word-level helper functions. No dependencies.
package bve_pkg;

    localparam int unsigned WordCountDefault = 64;

    localparam int unsigned WORD_W     = 64;
    localparam int unsigned SIZE_W     = 13;
    localparam int unsigned FUNC_W     = 4;
    localparam int unsigned BIT_IDX_W  = 12;
    localparam int unsigned WORD_IDX_W = 6;
    localparam int unsigned COUNT_W    = 13;
    localparam int unsigned POS_W      = 12;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 13'd4096;

    typedef logic [FUNC_W-1:0] func_t;

    localparam func_t FN_SET       = 4'd0;
    localparam func_t FN_CLEAR     = 4'd1;
    localparam func_t FN_FLIP      = 4'd2;
    localparam func_t FN_TEST      = 4'd3;
    localparam func_t FN_COUNT     = 4'd4;
    localparam func_t FN_FIRST     = 4'd5;
    localparam func_t FN_LAST      = 4'd6;
    localparam func_t FN_WRITE     = 4'd7;
    localparam func_t FN_READ      = 4'd8;
    localparam func_t FN_AND       = 4'd9;
    localparam func_t FN_OR        = 4'd10;
    localparam func_t FN_XOR       = 4'd11;
    localparam func_t FN_INVERT    = 4'd12;
    localparam func_t FN_CLEAR_ALL = 4'd13;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_RMW   = 3'b010,
        ST_SWEEP = 3'b100
    } state_t;

    // What a pass over every word does with each word it reads
    typedef enum logic [2:0] {
        SW_CLEAR,
        SW_TRIM,
        SW_INVERT,
        SW_COUNT,
        SW_FIRST,
        SW_LAST
    } sweep_op_t;

    // Bits of word widx that lie below the live size
    function automatic logic [WORD_W-1:0] word_mask(input logic [SIZE_W-1:0] live,
                                                   input logic [31:0] widx);
        logic [31:0] base;
        logic [31:0] n;
        logic [31:0] diff;
        base = {widx[25:0], 6'b0};
        n    = 32'(live);
        diff = n - base;
        if (base >= n)
            word_mask = '0;
        else if (diff >= 32'd64)
            word_mask = '1;
        else
            word_mask = (64'd1 << diff[5:0]) - 64'd1;
    endfunction

    function automatic logic [6:0] popcount64(input logic [WORD_W-1:0] v);
        logic [6:0] c;
        c = '0;
        for (int i = 0; i < WORD_W; i++)
            c = c + 7'(v[i]);
        return c;
    endfunction

    // Lowest set bit, binary search; value must be non-zero
    function automatic logic [5:0] low_one(input logic [WORD_W-1:0] v);
        logic [WORD_W-1:0] t;
        logic [5:0]        k;
        t = v;
        k = '0;
        if (t[31:0] == '0) begin k[5] = 1'b1; t = t >> 32; end
        if (t[15:0] == '0) begin k[4] = 1'b1; t = t >> 16; end
        if (t[7:0] == '0)  begin k[3] = 1'b1; t = t >> 8;  end
        if (t[3:0] == '0)  begin k[2] = 1'b1; t = t >> 4;  end
        if (t[1:0] == '0)  begin k[1] = 1'b1; t = t >> 2;  end
        if (!t[0])         k[0] = 1'b1;
        return k;
    endfunction

    // Highest set bit, binary search; value must be non-zero
    function automatic logic [5:0] high_one(input logic [WORD_W-1:0] v);
        logic [WORD_W-1:0] t;
        logic [5:0]        k;
        t = v;
        k = '0;
        if (t[63:32] != '0) begin k[5] = 1'b1; t = t >> 32; end
        if (t[31:16] != '0) begin k[4] = 1'b1; t = t >> 16; end
        if (t[15:8] != '0)  begin k[3] = 1'b1; t = t >> 8;  end
        if (t[7:4] != '0)   begin k[2] = 1'b1; t = t >> 4;  end
        if (t[3:2] != '0)   begin k[1] = 1'b1; t = t >> 2;  end
        if (t[1])           k[0] = 1'b1;
        return k;
    endfunction

endpackage

/* rtl/core/bve_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module bve_ram #(
    parameter int unsigned WIDTH  = 64,
    parameter int unsigned DEPTH  = 64,
    parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/core/bit_vector_engine_top.sv */
// Bit vector engine top level: bit store in one RAM, read-modify-write and
// whole-vector sweeps. Depends on bve_pkg and bve_ram.
//
//  channel  | handshake                       | payload
//  ---------+---------------------------------+------------------------------------
//  command  | start / busy (taken: !busy)     | func, bit_index, word_index, word_data
//  result   | done strobe, one cycle          | bit_state, set_count, position, found,
//           |                                 | word_out, index_error
//  config   | cfg_valid / cfg_ready           | size_bits
//
// Bit and word commands do one RAM read, then one write unless the command only reads or is flagged.
// Count, find, invert and clear-all sweep the RAM one word a cycle.
// After reset a clearing pass over every word keeps busy high; a size write
// starts a trim pass over every word. Results cannot be stalled by the receiver.
module bit_vector_engine_top
    import bve_pkg::*;
#(
    parameter int unsigned WORD_COUNT = WordCountDefault
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [FUNC_W-1:0]     func,
    input  logic [BIT_IDX_W-1:0]  bit_index,
    input  logic [WORD_IDX_W-1:0] word_index,
    input  logic [WORD_W-1:0]     word_data,
    output logic                  done,
    output logic                  bit_state,
    output logic [COUNT_W-1:0]    set_count,
    output logic [POS_W-1:0]      position,
    output logic                  found,
    output logic [WORD_W-1:0]     word_out,
    output logic                  index_error,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [SIZE_W-1:0]     size_bits
);

    localparam int unsigned AW    = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
    localparam int unsigned CNT_W = AW + 1;
    localparam int unsigned TOT_W = $clog2(WORD_COUNT * 64 + 1);
    localparam logic [31:0] CAP   = 32'(WORD_COUNT * 64);
    localparam logic [CNT_W-1:0] CNT_END   = CNT_W'(WORD_COUNT);
    localparam logic [AW-1:0]    LAST_ADDR = AW'(WORD_COUNT - 1);

    state_t             state_reg, state_next;
    sweep_op_t          sop_reg, sop_next;
    logic               report_reg, report_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               rd_valid_reg, rd_valid_next;
    logic [AW-1:0]      rd_addr_reg, rd_addr_next;
    logic [SIZE_W-1:0]  size_reg, size_next;
    logic               found_reg, found_next;
    logic               done_reg, done_next;

    func_t              func_reg, func_next;
    logic [AW-1:0]      addr_reg, addr_next;
    logic               err_reg, err_next;
    logic [5:0]         bsel_reg, bsel_next;
    logic [WORD_W-1:0]  data_reg, data_next;
    logic [TOT_W-1:0]   tot_reg, tot_next;
    logic [POS_W-1:0]   pos_reg, pos_next;

    logic               bit_state_reg, bit_state_next;
    logic [COUNT_W-1:0] set_count_reg, set_count_next;
    logic [POS_W-1:0]   position_reg, position_next;
    logic               found_out_reg, found_out_next;
    logic [WORD_W-1:0]  word_out_reg, word_out_next;
    logic               index_error_reg, index_error_next;

    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [WORD_W-1:0]  ram_wdata;
    logic [AW-1:0]      ram_raddr;
    logic [WORD_W-1:0]  rdata;

    logic [SIZE_W-1:0]  live;
    logic               is_bit_cmd, is_word_cmd, acc_sweep, acc_err;
    logic [AW-1:0]      acc_addr;
    sweep_op_t          acc_sop;

    logic [WORD_W-1:0]  mask, bit_m, rmw_word, sweep_word;
    logic               rmw_we, sweep_we, rdata_nz;
    logic [TOT_W-1:0]   tot_sum;
    logic               found_upd;
    logic [POS_W-1:0]   pos_upd;

    bve_ram #(
        .WIDTH  (WORD_W),
        .DEPTH  (WORD_COUNT),
        .ADDR_W (AW)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (rdata)
    );

    // Size above the capacity acts as the capacity
    assign live = (32'(size_reg) > CAP) ? CAP[SIZE_W-1:0] : size_reg;

    // Command decode at accept
    assign is_bit_cmd  = (func <= FN_TEST);
    assign is_word_cmd = (func >= FN_WRITE) && (func <= FN_XOR);
    assign acc_addr    = is_bit_cmd ? AW'(bit_index[11:6]) : AW'(word_index);
    assign acc_err     = is_bit_cmd  ? (SIZE_W'(bit_index) >= live) :
                         is_word_cmd ? (SIZE_W'({word_index, 6'b0}) >= live) : 1'b0;

    always_comb
    begin
        acc_sweep = 1'b1;
        acc_sop   = SW_CLEAR;
        case (func)
            FN_COUNT:     acc_sop = SW_COUNT;
            FN_FIRST:     acc_sop = SW_FIRST;
            FN_LAST:      acc_sop = SW_LAST;
            FN_INVERT:    acc_sop = SW_INVERT;
            FN_CLEAR_ALL: acc_sop = SW_CLEAR;
            default:      acc_sweep = 1'b0;
        endcase
    end

    // Word datapath
    assign mask  = word_mask(live, 32'((state_reg == ST_SWEEP) ? rd_addr_reg : addr_reg));
    assign bit_m = 64'd1 << bsel_reg;

    always_comb
    begin
        case (func_reg)
            FN_SET:   rmw_word = rdata | bit_m;
            FN_CLEAR: rmw_word = rdata & ~bit_m;
            FN_FLIP:  rmw_word = rdata ^ bit_m;
            FN_WRITE: rmw_word = data_reg & mask;
            FN_READ:  rmw_word = rdata & mask;
            FN_AND:   rmw_word = (rdata & data_reg) & mask;
            FN_OR:    rmw_word = (rdata | data_reg) & mask;
            FN_XOR:   rmw_word = (rdata ^ data_reg) & mask;
            default:  rmw_word = rdata;
        endcase
    end

    assign rmw_we = !err_reg && ((func_reg == FN_SET) || (func_reg == FN_CLEAR) ||
                                 (func_reg == FN_FLIP) || (func_reg == FN_WRITE) ||
                                 (func_reg == FN_AND) || (func_reg == FN_OR) ||
                                 (func_reg == FN_XOR));

    assign rdata_nz = |rdata;
    assign tot_sum  = tot_reg + TOT_W'(popcount64(rdata));

    always_comb
    begin
        sweep_word = rdata;
        sweep_we   = 1'b0;
        found_upd  = found_reg;
        pos_upd    = pos_reg;
        case (sop_reg)
            SW_CLEAR:
            begin
                sweep_word = '0;
                sweep_we   = 1'b1;
            end
            SW_TRIM:
            begin
                sweep_word = rdata & mask;
                sweep_we   = 1'b1;
            end
            SW_INVERT:
            begin
                sweep_word = ~rdata & mask;
                sweep_we   = 1'b1;
            end
            SW_FIRST:
            begin
                if (rdata_nz && !found_reg)
                begin
                    found_upd = 1'b1;
                    pos_upd   = POS_W'({rd_addr_reg, low_one(rdata)});
                end
            end
            SW_LAST:
            begin
                // ascending walk: the last non-zero word wins
                if (rdata_nz)
                begin
                    found_upd = 1'b1;
                    pos_upd   = POS_W'({rd_addr_reg, high_one(rdata)});
                end
            end
            default:
            begin
                sweep_we = 1'b0;
            end
        endcase
    end

    // Control
    always_comb
    begin
        state_next       = state_reg;
        sop_next         = sop_reg;
        report_next      = report_reg;
        cnt_next         = cnt_reg;
        rd_valid_next    = rd_valid_reg;
        rd_addr_next     = rd_addr_reg;
        size_next        = size_reg;
        found_next       = found_reg;
        done_next        = 1'b0;
        func_next        = func_reg;
        addr_next        = addr_reg;
        err_next         = err_reg;
        bsel_next        = bsel_reg;
        data_next        = data_reg;
        tot_next         = tot_reg;
        pos_next         = pos_reg;
        bit_state_next   = bit_state_reg;
        set_count_next   = set_count_reg;
        position_next    = position_reg;
        found_out_next   = found_out_reg;
        word_out_next    = word_out_reg;
        index_error_next = index_error_reg;
        ram_we           = 1'b0;
        ram_waddr        = addr_reg;
        ram_wdata        = rmw_word;
        ram_raddr        = (state_reg == ST_SWEEP) ? cnt_reg[AW-1:0] : acc_addr;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    func_next = func;
                    addr_next = acc_addr;
                    err_next  = acc_err;
                    bsel_next = bit_index[5:0];
                    data_next = word_data;
                    if (acc_sweep)
                    begin
                        state_next    = ST_SWEEP;
                        sop_next      = acc_sop;
                        report_next   = 1'b1;
                        cnt_next      = '0;
                        rd_valid_next = 1'b0;
                        tot_next      = '0;
                        found_next    = 1'b0;
                        pos_next      = '0;
                    end
                    else
                    begin
                        state_next = ST_RMW;
                    end
                end
                else if (cfg_valid)
                begin
                    // new size: trim every word against it
                    size_next     = size_bits;
                    state_next    = ST_SWEEP;
                    sop_next      = SW_TRIM;
                    report_next   = 1'b0;
                    cnt_next      = '0;
                    rd_valid_next = 1'b0;
                end
            end
            ST_RMW:
            begin
                ram_we           = rmw_we;
                ram_waddr        = addr_reg;
                ram_wdata        = rmw_word;
                state_next       = ST_IDLE;
                done_next        = 1'b1;
                bit_state_next   = (func_reg <= FN_TEST) && !err_reg && |(rmw_word & bit_m);
                set_count_next   = '0;
                position_next    = '0;
                found_out_next   = 1'b0;
                word_out_next    = ((func_reg >= FN_WRITE) && (func_reg <= FN_XOR) && !err_reg)
                                   ? rmw_word : '0;
                index_error_next = err_reg;
            end
            ST_SWEEP:
            begin
                if (cnt_reg != CNT_END)
                begin
                    cnt_next      = cnt_reg + 1'b1;
                    rd_valid_next = 1'b1;
                    rd_addr_next  = cnt_reg[AW-1:0];
                end
                else
                begin
                    rd_valid_next = 1'b0;
                end
                if (rd_valid_reg)
                begin
                    ram_we     = sweep_we;
                    ram_waddr  = rd_addr_reg;
                    ram_wdata  = sweep_word;
                    tot_next   = tot_sum;
                    found_next = found_upd;
                    pos_next   = pos_upd;
                    if (rd_addr_reg == LAST_ADDR)
                    begin
                        state_next       = ST_IDLE;
                        done_next        = report_reg;
                        bit_state_next   = 1'b0;
                        set_count_next   = (sop_reg == SW_COUNT) ? COUNT_W'(tot_sum) : '0;
                        found_out_next   = ((sop_reg == SW_FIRST) || (sop_reg == SW_LAST))
                                           && found_upd;
                        position_next    = ((sop_reg == SW_FIRST) || (sop_reg == SW_LAST))
                                           ? pos_upd : '0;
                        word_out_next    = '0;
                        index_error_next = 1'b0;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            // clearing pass runs straight out of reset
            state_reg    <= ST_SWEEP;
            sop_reg      <= SW_CLEAR;
            report_reg   <= 1'b0;
            cnt_reg      <= '0;
            rd_valid_reg <= 1'b0;
            rd_addr_reg  <= '0;
            size_reg     <= SIZE_RESET;
            found_reg    <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            sop_reg      <= sop_next;
            report_reg   <= report_next;
            cnt_reg      <= cnt_next;
            rd_valid_reg <= rd_valid_next;
            rd_addr_reg  <= rd_addr_next;
            size_reg     <= size_next;
            found_reg    <= found_next;
            done_reg     <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg        <= func_next;
        addr_reg        <= addr_next;
        err_reg         <= err_next;
        bsel_reg        <= bsel_next;
        data_reg        <= data_next;
        tot_reg         <= tot_next;
        pos_reg         <= pos_next;
        bit_state_reg   <= bit_state_next;
        set_count_reg   <= set_count_next;
        position_reg    <= position_next;
        found_out_reg   <= found_out_next;
        word_out_reg    <= word_out_next;
        index_error_reg <= index_error_next;
    end

    assign busy        = (state_reg != ST_IDLE);
    assign cfg_ready   = (state_reg == ST_IDLE) && !start;
    assign done        = done_reg;
    assign bit_state   = bit_state_reg;
    assign set_count   = set_count_reg;
    assign position    = position_reg;
    assign found       = found_out_reg;
    assign word_out    = word_out_reg;
    assign index_error = index_error_reg;

endmodule

/* rtl/core/bve_checker.sv */
// Port-level checker for the bit vector engine, bound to the top level.
// Depends on bve_pkg and bit_vector_engine_top_assert.svh.
`include "bit_vector_engine_top_assert.svh"

module bve_checker
    import bve_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 start,
    input logic                 busy,
    input logic                 done,
    input logic                 cfg_valid,
    input logic                 cfg_ready,
    input logic                 bit_state,
    input logic [COUNT_W-1:0]   set_count,
    input logic [POS_W-1:0]     position,
    input logic                 found,
    input logic [WORD_W-1:0]    word_out,
    input logic                 index_error
);

    `BVE_ASSERT_IMPLY(a_done_idle, done, !busy, "result strobe while busy")
    `BVE_ASSERT_NEXT(a_start_busy, start && !busy, busy && !done, "transaction taken but not busy")
    `BVE_ASSERT_NEXT(a_cfg_trim, cfg_valid && cfg_ready, busy, "size write did not start trim")
    `BVE_ASSERT_IMPLY(a_err_zero, done && index_error,
                      !bit_state && (set_count == '0) && !found && (word_out == '0),
                      "flagged command returned data")
    `BVE_ASSERT_IMPLY(a_nofind_pos, done && !found, position == '0,
                      "position set without a find")

endmodule

bind bit_vector_engine_top bve_checker u_bve_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .done        (done),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .bit_state   (bit_state),
    .set_count   (set_count),
    .position    (position),
    .found       (found),
    .word_out    (word_out),
    .index_error (index_error)
);
